>>> hw/rtl/cdpt_pkg.sv
package cdpt_pkg;

  localparam int FRAMES_PER_SEC = 75;
  localparam int SECS_PER_MIN   = 60;
  localparam int MINUTE_MAX     = 99;
  localparam int SECOND_MAX     = 59;
  localparam int FRAME_MAX      = 74;

  // x / 75 == (x * DIV75_MUL) >> DIV75_SHIFT for every x below 2**19.
  localparam int DIV75_MUL   = 447393;
  localparam int DIV75_SHIFT = 25;

  localparam logic [1:0] FUNC_LOST   = 2'd0;
  localparam logic [1:0] FUNC_TOC    = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;

  localparam logic [2:0] AS_PLAY  = 3'd0;
  localparam logic [2:0] AS_PAUSE = 3'd1;
  localparam logic [2:0] AS_DONE  = 3'd2;
  localparam logic [2:0] AS_NONE  = 3'd3;

  localparam logic [2:0] MODE_WAIT  = 3'd0;
  localparam logic [2:0] MODE_PLAY  = 3'd1;
  localparam logic [2:0] MODE_PAUSE = 3'd3;
  localparam logic [2:0] MODE_STOP  = 3'd4;
  localparam logic [2:0] MODE_EJECT = 3'd5;

  localparam logic [1:0] ST_NO_DISC  = 2'd0;
  localparam logic [1:0] ST_PRESENT  = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;

  typedef struct packed {
    logic [18:0] start_frame;
    logic [12:0] seconds;
  } toc_entry_t;

  typedef struct packed {
    logic [4:0] pad;
    logic [6:0] subchannel_index;
    logic [6:0] subchannel_track;
    logic [2:0] audio_status;
    logic [6:0] frame_in_second;
    logic [5:0] second;
    logic [6:0] minute;
    logic [6:0] track_count;
    logic [6:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [12:0] disc_length_seconds;
    logic [12:0] track_length_seconds;
    logic [12:0] relative_seconds;
    logic [18:0] absolute_frame;
    logic [12:0] absolute_seconds;
    logic [6:0]  current_index;
    logic [6:0]  current_track;
    logic [2:0]  mode;
  } out_item_t;

  localparam int IN_DATA_W  = $bits(in_item_t);
  localparam int OUT_DATA_W = $bits(out_item_t);

  typedef struct packed {
    logic [19:0] a;
    logic [19:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [19:0] diff;
    logic        ge;
  } alu_rsp_t;

  function automatic logic [12:0] addr_to_seconds(input logic [6:0] min_v,
                                                  input logic [5:0] sec_v);
    logic [6:0] m;
    logic [5:0] s;
    m = (min_v > 7'(MINUTE_MAX)) ? 7'(MINUTE_MAX) : min_v;
    s = (sec_v > 6'(SECOND_MAX)) ? 6'(SECOND_MAX) : sec_v;
    return 13'(m) * 13'(SECS_PER_MIN) + 13'(s);
  endfunction

  function automatic logic [18:0] seconds_to_frames(input logic [12:0] secs,
                                                    input logic [6:0]  frm_v);
    logic [6:0] f;
    f = (frm_v > 7'(FRAME_MAX)) ? 7'(FRAME_MAX) : frm_v;
    return 19'(secs) * 19'(FRAMES_PER_SEC) + 19'(f);
  endfunction

  function automatic logic [19:0] disc_limit(input logic [12:0] secs);
    return (20'(secs) + 20'd1) * 20'(FRAMES_PER_SEC);
  endfunction

endpackage

>>> hw/rtl/cdpt_toc_mem.sv
module cdpt_toc_mem #(
  parameter int DEPTH = 100,
  parameter int AW    = 7
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  cdpt_pkg::toc_entry_t  wr_data,
  input  logic [AW-1:0]         rd_addr,
  output cdpt_pkg::toc_entry_t  rd_data
);

  cdpt_pkg::toc_entry_t mem [DEPTH];
  cdpt_pkg::toc_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/cdpt_alu.sv
module cdpt_alu (
  input  cdpt_pkg::alu_req_t req,
  output cdpt_pkg::alu_rsp_t rsp
);

  logic [20:0] wide;

  // One subtractor serves every frame and seconds compare and difference of the sequencer.
  assign wide     = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.diff = wide[19:0];
  assign rsp.ge   = ~wide[20];

endmodule

>>> hw/rtl/cd_position_tracker_core.sv
// CD position tracker. The block keeps the disc's table of contents in a
// memory with one write port and one read port and turns each status
// request into player mode, track, index, absolute and relative position
// and track length; every request returns exactly one result. A status
// request runs a track search when the play address leaves the cached track;
// the search reads the TOC memory one entry per cycle through its only read
// port and compares each start frame in the shared subtractor. The block
// takes no new request while one is in work, but it does take one while the
// previous result still waits in the output register.
module cd_position_tracker_core #(
  parameter int MAX_TRACKS = 99
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // entry_index, track_count, minute, second, frame_in_second,
  // audio_status, subchannel_track, subchannel_index, zero fill
  input  logic [cdpt_pkg::IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // mode, current_track, current_index, absolute_seconds, absolute_frame,
  // relative_seconds, track_length_seconds, disc_length_seconds
  output logic [cdpt_pkg::OUT_DATA_W-1:0] out_tdata,
  // status_code
  output logic [1:0]                      out_tuser
);

  localparam int         DEPTH   = MAX_TRACKS + 1;
  localparam int         AW      = $clog2(DEPTH);
  localparam logic [6:0] TOD_MAX = 7'(MAX_TRACKS);
  localparam logic [6:0] TRK_CAP = 7'(MAX_TRACKS + 1);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_CONV       = 5'd1;
  localparam logic [4:0] S_FRM        = 5'd2;
  localparam logic [4:0] S_TOCWR      = 5'd3;
  localparam logic [4:0] S_EJECT      = 5'd4;
  localparam logic [4:0] S_DISC       = 5'd5;
  localparam logic [4:0] S_STAT       = 5'd6;
  localparam logic [4:0] S_POS        = 5'd7;
  localparam logic [4:0] S_POS_LO     = 5'd8;
  localparam logic [4:0] S_POS_HI     = 5'd9;
  localparam logic [4:0] S_SRCH_ISSUE = 5'd10;
  localparam logic [4:0] S_SRCH       = 5'd11;
  localparam logic [4:0] S_BUMP       = 5'd12;
  localparam logic [4:0] S_FIN        = 5'd13;
  localparam logic [4:0] S_REL        = 5'd14;
  localparam logic [4:0] S_MUL        = 5'd15;
  localparam logic [4:0] S_DIV        = 5'd16;
  localparam logic [4:0] S_LEN        = 5'd17;
  localparam logic [4:0] S_LEN_A      = 5'd18;
  localparam logic [4:0] S_LEN_B      = 5'd19;
  localparam logic [4:0] S_LEN_ONE    = 5'd20;
  localparam logic [4:0] S_RESP       = 5'd21;

  logic [4:0]  state_r, state_nxt;
  cdpt_pkg::in_item_t item_r, item_nxt;
  logic [1:0]  func_r, func_nxt;
  logic [1:0]  code_r, code_nxt;
  logic [12:0] secs_calc_r, secs_calc_nxt;
  logic [18:0] frm_calc_r, frm_calc_nxt;
  logic [19:0] lim_r, lim_nxt;
  logic [12:0] tmp_secs_r, tmp_secs_nxt;
  logic [18:0] rel_diff_r, rel_diff_nxt;
  logic [37:0] prod_r, prod_nxt;

  logic [6:0]  tod_r, tod_nxt;
  logic [12:0] disc_r, disc_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [6:0]  track_r, track_nxt;
  logic [6:0]  index_r, index_nxt;
  logic [12:0] abs_sec_r, abs_sec_nxt;
  logic [18:0] abs_frm_r, abs_frm_nxt;
  logic [12:0] rel_r, rel_nxt;
  logic [12:0] tlen_r, tlen_nxt;

  logic        out_valid_r, out_valid_nxt;
  cdpt_pkg::out_item_t out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;

  logic        wr_en;
  cdpt_pkg::toc_entry_t wr_data;
  cdpt_pkg::toc_entry_t rd_data;
  logic [6:0]  rd_idx;
  logic [6:0]  trk_m1;
  logic [6:0]  trk_p1;
  logic        mode_runs;
  cdpt_pkg::alu_req_t alu_req;
  cdpt_pkg::alu_rsp_t alu_rsp;

  cdpt_toc_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_toc_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(item_r.entry_index[AW-1:0]),
    .wr_data(wr_data),
    .rd_addr(rd_idx[AW-1:0]),
    .rd_data(rd_data)
  );

  cdpt_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  assign trk_m1    = track_r - 7'd1;
  assign trk_p1    = track_r + 7'd1;
  assign mode_runs = (mode_r == cdpt_pkg::MODE_PLAY) || (mode_r == cdpt_pkg::MODE_PAUSE);
  assign wr_data.start_frame = frm_calc_r;
  assign wr_data.seconds     = secs_calc_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    func_nxt      = func_r;
    code_nxt      = code_r;
    secs_calc_nxt = secs_calc_r;
    frm_calc_nxt  = frm_calc_r;
    lim_nxt       = lim_r;
    tmp_secs_nxt  = tmp_secs_r;
    rel_diff_nxt  = rel_diff_r;
    prod_nxt      = prod_r;
    tod_nxt       = tod_r;
    disc_nxt      = disc_r;
    mode_nxt      = mode_r;
    track_nxt     = track_r;
    index_nxt     = index_r;
    abs_sec_nxt   = abs_sec_r;
    abs_frm_nxt   = abs_frm_r;
    rel_nxt       = rel_r;
    tlen_nxt      = tlen_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    wr_en         = 1'b0;
    rd_idx        = track_r;
    alu_req.a     = 20'(abs_frm_r);
    alu_req.b     = 20'(rd_data.start_frame);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          item_nxt = cdpt_pkg::in_item_t'(in_tdata);
          func_nxt = in_tuser;
          case (in_tuser)
            cdpt_pkg::FUNC_LOST: begin
              mode_nxt    = cdpt_pkg::MODE_EJECT;
              track_nxt   = 7'd0;
              disc_nxt    = 13'd1;
              tlen_nxt    = 13'd1;
              abs_sec_nxt = 13'd0;
              rel_nxt     = 13'd0;
              abs_frm_nxt = 19'd0;
              code_nxt    = cdpt_pkg::ST_NO_DISC;
              state_nxt   = S_RESP;
            end
            cdpt_pkg::FUNC_TOC, cdpt_pkg::FUNC_STATUS: begin
              state_nxt = S_CONV;
            end
            default: begin
              code_nxt  = (mode_r == cdpt_pkg::MODE_EJECT) ? cdpt_pkg::ST_NO_DISC
                                                           : cdpt_pkg::ST_PRESENT;
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_CONV: begin
        secs_calc_nxt = cdpt_pkg::addr_to_seconds(item_r.minute, item_r.second);
        state_nxt     = S_FRM;
      end
      S_FRM: begin
        frm_calc_nxt = cdpt_pkg::seconds_to_frames(secs_calc_r, item_r.frame_in_second);
        state_nxt    = (func_r == cdpt_pkg::FUNC_TOC) ? S_TOCWR : S_EJECT;
      end
      S_TOCWR: begin
        wr_en     = (item_r.entry_index <= TOD_MAX);
        tod_nxt   = (item_r.track_count > TOD_MAX) ? TOD_MAX : item_r.track_count;
        code_nxt  = (mode_r == cdpt_pkg::MODE_EJECT) ? cdpt_pkg::ST_NO_DISC
                                                     : cdpt_pkg::ST_PRESENT;
        state_nxt = S_RESP;
      end
      S_EJECT: begin
        rd_idx = tod_r;
        if (mode_r == cdpt_pkg::MODE_EJECT) begin
          rel_nxt     = 13'd0;
          abs_sec_nxt = 13'd0;
          abs_frm_nxt = 19'd0;
          mode_nxt    = cdpt_pkg::MODE_STOP;
          code_nxt    = cdpt_pkg::ST_INSERTED;
          state_nxt   = S_DISC;
        end else begin
          code_nxt  = cdpt_pkg::ST_PRESENT;
          state_nxt = S_STAT;
        end
      end
      S_DISC: begin
        disc_nxt  = rd_data.seconds;
        state_nxt = S_STAT;
      end
      S_STAT: begin
        case (item_r.audio_status)
          cdpt_pkg::AS_PLAY: begin
            mode_nxt  = cdpt_pkg::MODE_PLAY;
            state_nxt = S_POS;
          end
          cdpt_pkg::AS_PAUSE: begin
            if (mode_runs) begin
              mode_nxt  = cdpt_pkg::MODE_PAUSE;
              state_nxt = S_POS;
            end else begin
              mode_nxt  = cdpt_pkg::MODE_STOP;
              state_nxt = S_FIN;
            end
          end
          cdpt_pkg::AS_DONE: begin
            mode_nxt  = cdpt_pkg::MODE_WAIT;
            rel_nxt   = 13'd0;
            state_nxt = S_RESP;
          end
          cdpt_pkg::AS_NONE: begin
            mode_nxt  = cdpt_pkg::MODE_STOP;
            rel_nxt   = 13'd0;
            state_nxt = S_FIN;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_POS: begin
        abs_sec_nxt = secs_calc_r;
        abs_frm_nxt = frm_calc_r;
        index_nxt   = item_r.subchannel_index;
        rd_idx      = trk_m1;
        state_nxt   = (track_r == 7'd0) ? S_SRCH_ISSUE : S_POS_LO;
      end
      S_POS_LO: begin
        // Frame below the cached track's start: search again from the top.
        lim_nxt = cdpt_pkg::disc_limit(disc_r);
        rd_idx  = track_r;
        if (!alu_rsp.ge) begin
          track_nxt = 7'd0;
          state_nxt = S_SRCH_ISSUE;
        end else begin
          state_nxt = S_POS_HI;
        end
      end
      S_POS_HI: begin
        if (track_r >= tod_r) begin
          alu_req.b = lim_r;
        end
        if (alu_rsp.ge) begin
          track_nxt = 7'd0;
          state_nxt = S_SRCH_ISSUE;
        end else begin
          state_nxt = S_BUMP;
        end
      end
      S_SRCH_ISSUE: begin
        rd_idx    = track_r;
        state_nxt = (track_r < tod_r) ? S_SRCH : S_BUMP;
      end
      S_SRCH: begin
        // The next entry is fetched while the current one is compared.
        rd_idx = trk_p1;
        if (alu_rsp.ge) begin
          track_nxt = trk_p1;
          state_nxt = (trk_p1 < tod_r) ? S_SRCH : S_BUMP;
        end else begin
          state_nxt = S_BUMP;
        end
      end
      S_BUMP: begin
        if ((track_r != 7'd0) && (item_r.subchannel_track > track_r) &&
            (track_r < TRK_CAP)) begin
          track_nxt = trk_p1;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        rd_idx = trk_m1;
        if (mode_runs && (track_r != 7'd0) && (track_r <= tod_r)) begin
          state_nxt = S_REL;
        end else begin
          rel_nxt   = 13'd0;
          state_nxt = S_LEN;
        end
      end
      S_REL: begin
        if (alu_rsp.ge) begin
          rel_diff_nxt = alu_rsp.diff[18:0];
          state_nxt    = S_MUL;
        end else begin
          rel_nxt   = 13'd0;
          state_nxt = S_LEN;
        end
      end
      S_MUL: begin
        prod_nxt  = 38'(rel_diff_r) * 38'(cdpt_pkg::DIV75_MUL);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rel_nxt   = prod_r[cdpt_pkg::DIV75_SHIFT +: 13];
        state_nxt = S_LEN;
      end
      S_LEN: begin
        if (track_r == 7'd0) begin
          rd_idx    = tod_r;
          state_nxt = S_LEN_ONE;
        end else if (trk_m1 < tod_r) begin
          rd_idx    = track_r;
          state_nxt = S_LEN_A;
        end else begin
          rd_idx    = trk_m1;
          state_nxt = S_LEN_ONE;
        end
      end
      S_LEN_A: begin
        tmp_secs_nxt = rd_data.seconds;
        rd_idx       = trk_m1;
        state_nxt    = S_LEN_B;
      end
      S_LEN_B: begin
        alu_req.a = 20'(tmp_secs_r);
        alu_req.b = 20'(rd_data.seconds);
        tlen_nxt  = alu_rsp.ge ? alu_rsp.diff[12:0] : 13'd0;
        state_nxt = S_RESP;
      end
      S_LEN_ONE: begin
        tlen_nxt  = rd_data.seconds;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt                     = 1'b1;
          out_user_nxt                      = code_r;
          out_data_nxt.mode                 = mode_r;
          out_data_nxt.current_track        = track_r;
          out_data_nxt.current_index        = index_r;
          out_data_nxt.absolute_seconds     = abs_sec_r;
          out_data_nxt.absolute_frame       = abs_frm_r;
          out_data_nxt.relative_seconds     = rel_r;
          out_data_nxt.track_length_seconds = tlen_r;
          out_data_nxt.disc_length_seconds  = disc_r;
          state_nxt                         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tod_r       <= 7'd0;
      disc_r      <= 13'd1;
      mode_r      <= cdpt_pkg::MODE_EJECT;
      track_r     <= 7'd0;
      index_r     <= 7'd0;
      abs_sec_r   <= 13'd0;
      abs_frm_r   <= 19'd0;
      rel_r       <= 13'd0;
      tlen_r      <= 13'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tod_r       <= tod_nxt;
      disc_r      <= disc_nxt;
      mode_r      <= mode_nxt;
      track_r     <= track_nxt;
      index_r     <= index_nxt;
      abs_sec_r   <= abs_sec_nxt;
      abs_frm_r   <= abs_frm_nxt;
      rel_r       <= rel_nxt;
      tlen_r      <= tlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    func_r      <= func_nxt;
    code_r      <= code_nxt;
    secs_calc_r <= secs_calc_nxt;
    frm_calc_r  <= frm_calc_nxt;
    lim_r       <= lim_nxt;
    tmp_secs_r  <= tmp_secs_nxt;
    rel_diff_r  <= rel_diff_nxt;
    prod_r      <= prod_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while a previous one was in work");

  a_eject_clears_position: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == cdpt_pkg::MODE_EJECT) |-> (track_r == 7'd0) && (abs_frm_r == 19'd0))
    else $error("ejected player holds a track or a position");

  a_track_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (track_r <= TRK_CAP) && (tod_r <= TOD_MAX))
    else $error("track or track count beyond its limit");

  a_search_in_toc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (track_r < tod_r))
    else $error("track search walked past the last TOC entry");
`endif

endmodule

>>> bench/tb_cd_position_tracker_core.sv
`timescale 1ns / 1ps

module tb_cd_position_tracker_core;
  import cdpt_pkg::*;

  localparam int TRACKS_MAX = 99;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [2:0] AS_OTHER = 3'd4;
  localparam int DISC_FRAMES = (MINUTE_MAX + 1) * SECS_PER_MIN * FRAMES_PER_SEC;
  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 600;
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic [TRACKS_MAX:0]       written;
    logic [TRACKS_MAX:0][18:0] start_frame;
    logic [TRACKS_MAX:0][12:0] secs;
    logic [6:0]                tracks;
    logic [12:0]               disc_secs;
    logic [2:0]                mode;
    logic [6:0]                trk;
    logic [6:0]                idx;
    logic [12:0]               abs_secs;
    logic [18:0]               abs_frame;
    logic [12:0]               rel_secs;
    logic [12:0]               trk_secs;
  } player_t;

  typedef struct packed {
    logic [1:0] code;
    out_item_t  body;
  } report_t;

  class track_scoreboard;
    player_t pl;
    logic touched_blank;
    report_t expected_reports[$];
    int errors;
    int checked;

    function new();
      pl = '0;
      pl.disc_secs = 13'd1;
      pl.trk_secs = 13'd1;
      pl.mode = MODE_EJECT;
      errors = 0;
      checked = 0;
    endfunction

    function int sat_to(int v, int hi);
      return (v > hi) ? hi : v;
    endfunction

    function int start_of(int i);
      if (i > TRACKS_MAX) return 0;
      if (!pl.written[i]) touched_blank = 1'b1;
      return int'(pl.start_frame[i]);
    endfunction

    function int secs_of(int i);
      if (i > TRACKS_MAX) return 0;
      if (!pl.written[i]) touched_blank = 1'b1;
      return int'(pl.secs[i]);
    endfunction

    // Tracks past the TOC report the stored start seconds of the entry before.
    function int track_span(int trk);
      int i;
      int a;
      int b;
      i = trk - 1;
      if (i < int'(pl.tracks)) begin
        a = secs_of(i + 1);
        b = secs_of(i);
        return (a >= b) ? a - b : 0;
      end
      return secs_of(i);
    endfunction

    function void locate(in_item_t it);
      int n;
      int af;
      int lim;
      int trk;
      logic research;
      n = pl.tracks;
      pl.abs_secs = sat_to(it.minute, MINUTE_MAX) * SECS_PER_MIN + sat_to(it.second, SECOND_MAX);
      af = int'(pl.abs_secs) * FRAMES_PER_SEC + sat_to(it.frame_in_second, FRAME_MAX);
      pl.abs_frame = af;
      trk = pl.trk;
      research = (trk < 1);
      if (!research) begin
        lim = (trk >= n) ? (int'(pl.disc_secs) + 1) * FRAMES_PER_SEC : start_of(trk);
        research = (af < start_of(trk - 1)) || (af >= lim);
      end
      if (research) begin
        trk = 0;
        while (trk < n && af >= start_of(trk)) trk++;
      end
      if (trk >= 1 && int'(it.subchannel_track) > trk && trk < TRACKS_MAX + 1) trk++;
      pl.trk = trk;
      pl.idx = it.subchannel_index;
    endfunction

    function void settle();
      int trk;
      int af;
      int s;
      trk = pl.trk;
      af = pl.abs_frame;
      if ((pl.mode == MODE_PLAY || pl.mode == MODE_PAUSE) && trk >= 1 && trk <= int'(pl.tracks))
      begin
        s = start_of(trk - 1);
        pl.rel_secs = (af >= s) ? (af - s) / FRAMES_PER_SEC : 0;
      end else begin
        pl.rel_secs = '0;
      end
      pl.trk_secs = (trk < 1) ? secs_of(pl.tracks) : track_span(trk);
    endfunction

    function void advance_player(logic [1:0] func, in_item_t it, output report_t rep);
      int secs;
      rep.code = ST_PRESENT;
      case (func)
        FUNC_LOST: begin
          pl.mode = MODE_EJECT;
          pl.trk = '0;
          pl.disc_secs = 13'd1;
          pl.trk_secs = 13'd1;
          pl.abs_secs = '0;
          pl.rel_secs = '0;
          pl.abs_frame = '0;
          rep.code = ST_NO_DISC;
        end
        FUNC_STATUS: begin
          if (pl.mode == MODE_EJECT) begin
            pl.rel_secs = '0;
            pl.abs_secs = '0;
            pl.abs_frame = '0;
            pl.disc_secs = secs_of(pl.tracks);
            pl.mode = MODE_STOP;
            rep.code = ST_INSERTED;
          end
          case (it.audio_status)
            AS_PLAY: begin
              pl.mode = MODE_PLAY;
              locate(it);
              settle();
            end
            AS_PAUSE: begin
              if (pl.mode == MODE_PLAY || pl.mode == MODE_PAUSE) begin
                pl.mode = MODE_PAUSE;
                locate(it);
              end else begin
                pl.mode = MODE_STOP;
              end
              settle();
            end
            AS_DONE: begin
              pl.mode = MODE_WAIT;
              pl.rel_secs = '0;
            end
            AS_NONE: begin
              pl.mode = MODE_STOP;
              pl.rel_secs = '0;
              settle();
            end
            default: ;
          endcase
        end
        default: begin
          if (func == FUNC_TOC) begin
            pl.tracks = sat_to(it.track_count, TRACKS_MAX);
            if (it.entry_index <= TRACKS_MAX) begin
              secs = sat_to(it.minute, MINUTE_MAX) * SECS_PER_MIN + sat_to(it.second, SECOND_MAX);
              pl.secs[it.entry_index] = secs;
              pl.start_frame[it.entry_index] =
                secs * FRAMES_PER_SEC + sat_to(it.frame_in_second, FRAME_MAX);
              pl.written[it.entry_index] = 1'b1;
            end
          end
          rep.code = (pl.mode == MODE_EJECT) ? ST_NO_DISC : ST_PRESENT;
        end
      endcase
      rep.body.mode = pl.mode;
      rep.body.current_track = pl.trk;
      rep.body.current_index = pl.idx;
      rep.body.absolute_seconds = pl.abs_secs;
      rep.body.absolute_frame = pl.abs_frame;
      rep.body.relative_seconds = pl.rel_secs;
      rep.body.track_length_seconds = pl.trk_secs;
      rep.body.disc_length_seconds = pl.disc_secs;
    endfunction

    // Tries a request on a copy of the player; true if it would read a TOC
    // entry that has never been written.
    function bit would_touch_blank(logic [1:0] func, in_item_t it);
      player_t keep;
      report_t rep;
      keep = pl;
      touched_blank = 1'b0;
      advance_player(func, it, rep);
      pl = keep;
      return touched_blank;
    endfunction

    function void note_request(logic [1:0] func, in_item_t it);
      report_t rep;
      advance_player(func, it, rep);
      expected_reports.push_back(rep);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task match_field(string name, int got, int want);
      if (got != want)
        report($sformatf("result %0d: %s is %0d, expected %0d", checked, name, got, want));
    endtask

    task check_result(logic [1:0] code, out_item_t got);
      report_t e;
      checked++;
      if (expected_reports.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", checked));
        return;
      end
      e = expected_reports.pop_front();
      match_field("status_code", code, e.code);
      match_field("mode", got.mode, e.body.mode);
      match_field("current_track", got.current_track, e.body.current_track);
      match_field("current_index", got.current_index, e.body.current_index);
      match_field("absolute_seconds", got.absolute_seconds, e.body.absolute_seconds);
      match_field("absolute_frame", got.absolute_frame, e.body.absolute_frame);
      match_field("relative_seconds", got.relative_seconds, e.body.relative_seconds);
      match_field("track_length_seconds", got.track_length_seconds,
                  e.body.track_length_seconds);
      match_field("disc_length_seconds", got.disc_length_seconds,
                  e.body.disc_length_seconds);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  track_scoreboard sb;
  int sent[4];
  int burst_left = 0;
  int steady = 0;
  int sessions = 0;
  int biggest_toc = 0;
  int quiet = 0;

  always #5 clk = ~clk;

  cd_position_tracker_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic in_item_t req(int entry, int tc, int mi, int se, int fr, int as,
                                   int st, int si);
    in_item_t it;
    it = '0;
    it.entry_index = 7'(entry);
    it.track_count = 7'(tc);
    it.minute = 7'(mi);
    it.second = 6'(se);
    it.frame_in_second = 7'(fr);
    it.audio_status = 3'(as);
    it.subchannel_track = 7'(st);
    it.subchannel_index = 7'(si);
    return it;
  endfunction

  function automatic in_item_t noise_item();
    return req($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
               $urandom_range(0, 63), $urandom_range(0, 127), $urandom_range(0, 7),
               $urandom_range(0, 127), $urandom_range(0, 127));
  endfunction

  function automatic in_item_t place(in_item_t it, int f);
    it.minute = 7'(f / (FRAMES_PER_SEC * SECS_PER_MIN));
    it.second = 6'((f / FRAMES_PER_SEC) % SECS_PER_MIN);
    it.frame_in_second = 7'(f % FRAMES_PER_SEC);
    return it;
  endfunction

  // One request per call. Requests that would read a never-written TOC
  // entry are turned into a disc-lost request.
  task automatic send(logic [1:0] f, in_item_t it);
    int gap;
    it.pad = '0;
    if (sb.would_touch_blank(f, it)) f = FUNC_LOST;
    if (burst_left == 0) begin
      gap = (steady != 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= it;
    do @(posedge clk); while (!in_tready);
    sb.note_request(f, it);
    sent[f]++;
  endtask

  task automatic directed_requests();
    send(FUNC_SPARE, req(127, 127, 127, 63, 127, 7, 127, 127));
    send(FUNC_LOST, req(0, 0, 0, 0, 0, 0, 0, 0));
    // Entry number out of range: stores nothing but still sets the track count.
    send(FUNC_TOC, req(127, 127, 127, 63, 127, 0, 0, 0));
    send(FUNC_TOC, req(0, 3, 0, 2, 0, 0, 0, 0));
    send(FUNC_TOC, req(1, 3, 4, 10, 30, 0, 0, 0));
    send(FUNC_TOC, req(2, 3, 8, 0, 74, 0, 0, 0));
    send(FUNC_TOC, req(3, 3, 127, 63, 127, 0, 0, 0));
    send(FUNC_STATUS, req(0, 0, 0, 1, 0, AS_PLAY, 1, 0));
    send(FUNC_STATUS, req(0, 0, 0, 2, 0, AS_PLAY, 1, 1));
    send(FUNC_STATUS, req(0, 0, 5, 0, 0, AS_PLAY, 3, 1));
    send(FUNC_STATUS, req(0, 0, 5, 1, 0, AS_PAUSE, 2, 2));
    send(FUNC_STATUS, req(0, 0, 6, 0, 0, AS_OTHER, 2, 2));
    send(FUNC_STATUS, req(0, 0, 6, 0, 0, 7, 2, 2));
    send(FUNC_STATUS, req(0, 0, 99, 59, 74, AS_PLAY, 127, 99));
    send(FUNC_STATUS, req(0, 0, 127, 63, 127, AS_PLAY, 127, 127));
    send(FUNC_STATUS, req(0, 0, 10, 0, 0, AS_DONE, 3, 1));
    send(FUNC_STATUS, req(0, 0, 10, 0, 0, AS_PAUSE, 3, 1));
    send(FUNC_STATUS, req(0, 0, 10, 0, 0, AS_NONE, 3, 1));
    // Entry 1 moved past entry 2, so lengths and offsets go negative.
    send(FUNC_TOC, req(1, 3, 9, 0, 0, 0, 0, 0));
    send(FUNC_STATUS, req(0, 0, 0, 5, 0, AS_PLAY, 2, 1));
    send(FUNC_LOST, req(5, 5, 5, 5, 5, 5, 5, 5));
    send(FUNC_STATUS, req(0, 0, 0, 0, 0, AS_NONE, 0, 0));
    send(FUNC_TOC, req(0, 0, 0, 0, 0, 0, 0, 0));
    send(FUNC_STATUS, req(0, 0, 0, 0, 30, AS_PLAY, 1, 1));
  endtask

  // A disc is loaded with a full TOC and then played with status requests
  // that mostly walk forward through it, with some noise mixed in.
  task automatic play_disc();
    int n;
    int per;
    int pos;
    int t;
    int r;
    int idx;
    int samples;
    int starts[TRACKS_MAX + 1];
    logic ragged;
    logic downward;
    in_item_t it;
    sessions++;
    steady = ($urandom_range(0, 4) == 0);
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(40, TRACKS_MAX) : $urandom_range(0, 12);
    if (n > biggest_toc) biggest_toc = n;
    ragged = ($urandom_range(0, 9) == 0);
    downward = ($urandom_range(0, 3) == 0);
    per = (DISC_FRAMES - 1000) / (n + 1);
    starts[0] = $urandom_range(0, 900);
    for (int k = 1; k <= n; k++)
      starts[k] = ragged ? $urandom_range(0, DISC_FRAMES - 1) : starts[k - 1] + $urandom_range(150, per);
    if ($urandom_range(0, 3) != 0) send(FUNC_LOST, noise_item());
    for (int k = 0; k <= n; k++) begin
      idx = downward ? n - k : k;
      it = place(noise_item(), starts[idx]);
      it.entry_index = 7'(idx);
      it.track_count = 7'(n);
      if (n == TRACKS_MAX && $urandom_range(0, 1) == 0) it.track_count = 7'($urandom_range(100, 127));
      if (idx == n && $urandom_range(0, 7) == 0) begin
        it.minute = 7'($urandom_range(100, 127));
        it.second = 6'($urandom_range(60, 63));
        it.frame_in_second = 7'($urandom_range(75, 127));
        starts[n] = DISC_FRAMES - 1;
      end
      send(FUNC_TOC, it);
      if ($urandom_range(0, 19) == 0) begin
        it.entry_index = 7'($urandom_range(100, 127));
        send(FUNC_TOC, it);
      end
    end
    samples = $urandom_range(8, 40);
    pos = starts[0] - $urandom_range(0, 200);
    if (pos < 0) pos = 0;
    for (int s = 0; s < samples; s++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send(FUNC_LOST, noise_item());
      end else if (r < 6) begin
        idx = $urandom_range(0, n);
        starts[idx] = $urandom_range(0, DISC_FRAMES - 1);
        it = place(noise_item(), starts[idx]);
        it.entry_index = 7'(idx);
        it.track_count = 7'(n);
        send(FUNC_TOC, it);
      end else if (r < 8) begin
        send(FUNC_SPARE, noise_item());
      end else begin
        if ($urandom_range(0, 7) == 0) pos = $urandom_range(0, DISC_FRAMES - 1);
        else pos += $urandom_range(0, 400);
        if (pos >= DISC_FRAMES) pos = starts[0];
        it = place(noise_item(), pos);
        if ($urandom_range(0, 29) == 0) begin
          it.minute = 7'($urandom_range(0, 127));
          it.second = 6'($urandom_range(0, 63));
          it.frame_in_second = 7'($urandom_range(0, 127));
        end
        t = 0;
        for (int k = 0; k < n; k++) if (pos >= starts[k]) t = k + 1;
        r = $urandom_range(0, 99);
        if (r < 55) it.subchannel_track = 7'(t);
        else if (r < 70) it.subchannel_track = 7'(t + 1);
        else if (r < 85) it.subchannel_track = 7'($urandom_range(0, 127));
        else it.subchannel_track = '0;
        if ($urandom_range(0, 3) != 0) it.subchannel_index = 7'($urandom_range(0, 2));
        r = $urandom_range(0, 99);
        if (r < 60) it.audio_status = AS_PLAY;
        else if (r < 72) it.audio_status = AS_PAUSE;
        else if (r < 80) it.audio_status = AS_DONE;
        else if (r < 88) it.audio_status = AS_NONE;
        else it.audio_status = 3'($urandom_range(AS_OTHER, 7));
        send(FUNC_STATUS, it);
      end
    end
  endtask

  initial begin
    int total;
    sb = new();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= FUNC_LOST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    directed_requests();
    total = sent[0] + sent[1] + sent[2] + sent[3];
    while (sent[0] + sent[1] + sent[2] + sent[3] - total < RANDOM_ITEMS) play_disc();
    in_tvalid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Requests: %0d disc-lost, %0d TOC, %0d status, %0d unused function; %0d results checked.",
             sent[FUNC_LOST], sent[FUNC_TOC], sent[FUNC_STATUS], sent[FUNC_SPARE], sb.checked);
    $display("Discs played: %0d, largest TOC %0d tracks, output held off %0d cycles once.",
             sessions, biggest_toc, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: a changing ready pattern plus one long hold-off that lets
  // the block back up into its input.
  initial begin
    int results;
    int seg_left;
    int seg_kind;
    int hold_left;
    logic held;
    logic ready;
    results = 0;
    seg_left = 0;
    seg_kind = 0;
    hold_left = 0;
    held = 1'b0;
    out_tready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tuser, out_tdata);
        results++;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else if (!held && results >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        ready = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_kind = $urandom_range(0, 2);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (seg_kind)
          0: ready = 1'b1;
          1: ready = $urandom_range(0, 1);
          default: ready = (seg_left % 4 == 0);
        endcase
      end
      out_tready <= ready;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("No request or result moved for %0d cycles.", quiet);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
